// ----- design/htfc_pkg.sv -----
// Shared types, constants and helper functions for the sensor frame checker.
// Used by htfc_front, htfc_back and the top level; depends on nothing.
package htfc_pkg;

  localparam logic [7:0] CrcInit = 8'hFF;
  localparam logic [7:0] CrcPoly = 8'h31;

  localparam logic [7:0]        TempScale = 8'd175;
  localparam logic [7:0]        HumScale  = 8'd125;
  localparam logic signed [9:0] TempBase  = -10'sd45;
  localparam logic signed [7:0] HumBase   = -8'sd6;
  localparam logic [16:0]       WordMax   = 17'd65535;

  localparam int CfgIndexW = 2;
  localparam logic [CfgIndexW-1:0] RegTempOffset  = 2'd0;
  localparam logic [CfgIndexW-1:0] RegTempFloor   = 2'd1;
  localparam logic [CfgIndexW-1:0] RegTempCeiling = 2'd2;

  localparam logic signed [4:0] TempOffsetReset  = -5'sd5;
  localparam logic signed [7:0] TempFloorReset   = 8'sd0;
  localparam logic signed [7:0] TempCeilingReset = 8'sd100;

  // Position within the six-byte answer
  typedef enum logic [2:0] {
    PosTempHi = 3'd0,
    PosTempLo = 3'd1,
    PosTempCrc = 3'd2,
    PosHumHi = 3'd3,
    PosHumLo = 3'd4,
    PosHumCrc = 3'd5
  } pos_t;

  typedef struct packed {
    logic signed [4:0] temp_offset;
    logic signed [7:0] temp_floor;
    logic signed [7:0] temp_ceiling;
  } cfg_t;

  // One checked frame, handed from the front to the back
  typedef struct packed {
    logic [15:0] raw_temp;
    logic [15:0] raw_humidity;
    logic        crc_error;
  } frame_t;

  typedef struct packed {
    logic [15:0]       raw_temp;
    logic [15:0]       raw_humidity;
    logic signed [7:0] temp_degrees;
    logic signed [7:0] humidity_percent;
    logic              crc_error;
  } result_t;

  // CRC-8, MSB first, one byte
  function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CrcPoly) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  // floor(x / 65535) for x below 256 * 65535, so that the quotient stays under 256
  function automatic logic [7:0] div_word_max(input logic [23:0] x);
    logic [7:0]  q;
    logic [16:0] r;
    q = x[23:16];
    r = {1'b0, x[15:0]} + {9'd0, q};
    if (r >= WordMax) begin
      q = q + 8'd1;
    end
    return q;
  endfunction

endpackage

// ----- design/htfc_fifo.sv -----
// Small register queue with combinational head read.
// Generic; depends on nothing.
module htfc_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [Width-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [Width-1:0] rdata,
  output logic             empty
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem [Depth];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CntW'(Depth));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CntW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

// ----- design/htfc_front.sv -----
// Front end: takes answer bytes, assembles both words and checks their CRCs.
// Depends on htfc_pkg.
module htfc_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  logic [7:0]      rx_byte,
  output logic            full,
  input  logic            frame_full,
  output logic            frame_push,
  output htfc_pkg::frame_t frame
);
  import htfc_pkg::*;

  pos_t        pos;
  pos_t        pos_next;
  logic [7:0]  crc;
  logic [7:0]  crc_next;
  logic [15:0] temp_word;
  logic [15:0] temp_word_next;
  logic [15:0] hum_word;
  logic [15:0] hum_word_next;
  logic        temp_bad;
  logic        temp_bad_next;
  logic        take;

  // Stall only on the last byte, and only when the frame cannot be queued
  assign full = (pos == PosHumCrc) && frame_full;
  assign take = push && !full;

  always_comb begin
    pos_next       = pos;
    crc_next       = crc;
    temp_word_next = temp_word;
    hum_word_next  = hum_word;
    temp_bad_next  = temp_bad;
    if (take) begin
      case (pos)
        PosTempHi: begin
          crc_next       = crc8_feed(CrcInit, rx_byte);
          temp_word_next = {rx_byte, 8'h00};
          pos_next       = PosTempLo;
        end
        PosTempLo: begin
          crc_next       = crc8_feed(crc, rx_byte);
          temp_word_next = {temp_word[15:8], rx_byte};
          pos_next       = PosTempCrc;
        end
        PosTempCrc: begin
          temp_bad_next = (crc != rx_byte);
          crc_next      = CrcInit;
          pos_next      = PosHumHi;
        end
        PosHumHi: begin
          crc_next      = crc8_feed(CrcInit, rx_byte);
          hum_word_next = {rx_byte, 8'h00};
          pos_next      = PosHumLo;
        end
        PosHumLo: begin
          crc_next      = crc8_feed(crc, rx_byte);
          hum_word_next = {hum_word[15:8], rx_byte};
          pos_next      = PosHumCrc;
        end
        default: begin
          crc_next      = CrcInit;
          temp_bad_next = 1'b0;
          pos_next      = PosTempHi;
        end
      endcase
    end
  end

  // Hand the checked frame on as the last byte of an answer goes in
  always_comb begin
    frame_push         = take && (pos == PosHumCrc);
    frame.raw_temp     = temp_word;
    frame.raw_humidity = hum_word;
    frame.crc_error    = temp_bad || (crc != rx_byte);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= PosTempHi;
      crc      <= CrcInit;
      temp_bad <= 1'b0;
    end else begin
      pos      <= pos_next;
      crc      <= crc_next;
      temp_bad <= temp_bad_next;
    end
  end

  always_ff @(posedge clk) begin
    temp_word <= temp_word_next;
    hum_word  <= hum_word_next;
  end

endmodule

// ----- design/htfc_back.sv -----
// Back end: scales checked frames to degrees and percent, applies offset and clamps.
// Depends on htfc_pkg; feeds the result queue in the top level.
module htfc_back (
  input  logic              clk,
  input  logic              rst,
  input  htfc_pkg::cfg_t    cfg,
  input  htfc_pkg::frame_t  frame,
  input  logic              frame_empty,
  output logic              frame_pop,
  input  logic              res_full,
  output logic              res_push,
  output htfc_pkg::result_t res
);
  import htfc_pkg::*;

  logic        s1_valid;
  logic        s1_load;
  logic [23:0] temp_prod;
  logic [23:0] hum_prod;
  frame_t      s1_frame;

  logic [7:0]        temp_q;
  logic [7:0]        hum_q;
  logic signed [9:0] t_conv;
  logic signed [9:0] t_ceil;
  logic signed [9:0] t_clamp;
  logic signed [9:0] ceil_ext;
  logic signed [9:0] floor_ext;
  logic signed [7:0] h_conv;

  // Advance the multiply stage when it is empty or its item leaves this cycle
  assign s1_load   = !s1_valid || !res_full;
  assign frame_pop = s1_load && !frame_empty;
  assign res_push  = s1_valid && !res_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= !frame_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_frame  <= frame;
      temp_prod <= {8'd0, frame.raw_temp} * {16'd0, TempScale};
      hum_prod  <= {8'd0, frame.raw_humidity} * {16'd0, HumScale};
    end
  end

  always_comb begin
    temp_q    = div_word_max(temp_prod);
    hum_q     = div_word_max(hum_prod);
    ceil_ext  = {{2{cfg.temp_ceiling[7]}}, cfg.temp_ceiling};
    floor_ext = {{2{cfg.temp_floor[7]}}, cfg.temp_floor};
    t_conv    = $signed({2'b00, temp_q}) + TempBase
                + $signed({{5{cfg.temp_offset[4]}}, cfg.temp_offset});
    // Ceiling first, then floor, so a floor above the ceiling wins
    t_ceil    = (t_conv > ceil_ext) ? ceil_ext : t_conv;
    t_clamp   = (t_ceil < floor_ext) ? floor_ext : t_ceil;
    h_conv    = $signed(hum_q) + HumBase;

    res.raw_temp     = s1_frame.raw_temp;
    res.raw_humidity = s1_frame.raw_humidity;
    res.crc_error    = s1_frame.crc_error;
    if (s1_frame.crc_error) begin
      res.temp_degrees     = 8'sd0;
      res.humidity_percent = 8'sd0;
    end else begin
      res.temp_degrees     = t_clamp[7:0];
      res.humidity_percent = h_conv;
    end
  end

endmodule

// ----- design/humidity_temp_frame_check_convert.sv -----
// Top level of the sensor answer checker and converter.
// Depends on htfc_pkg, htfc_fifo, htfc_front and htfc_back.
//
// Input: drive rx_byte with push high; the item is taken on a rising edge where
//   full is low. Six items make one answer: temperature high, low, CRC, humidity
//   high, low, CRC. There is no resync; only rst realigns the byte count.
// Output: while empty is low the oldest result sits on the result ports; pop it
//   with pop high. One result leaves per six bytes.
// Configuration: cfg_write with cfg_index and cfg_data sets temp_offset (0),
//   temp_floor (1) or temp_ceiling (2). Change them only while idle.
// Timing: one byte per cycle sustained while full stays low, set by the byte input
//   itself; the CRC is one unrolled step per byte and each scale is a 16x8 multiply
//   in a registered stage. A result passes from the frame queue through the
//   registered multiply stage into the result queue before it shows on the ports.
// Reset: rst (synchronous) empties both queues and the multiply stage, returns to
//   the first byte and loads offset -5, floor 0, ceiling 100.
// Stall: if pop is held low the result queue fills, then the frame queue; full
//   only rises on the sixth byte of an answer, so bytes one to five always go in.
module humidity_temp_frame_check_convert #(
  parameter int FrameDepth  = 2,
  parameter int ResultDepth = 2
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  input  logic [7:0]                         rx_byte,
  output logic                               full,
  input  logic                               pop,
  output logic                               empty,
  output logic [15:0]                        raw_temp,
  output logic [15:0]                        raw_humidity,
  output logic signed [7:0]                  temp_degrees,
  output logic signed [7:0]                  humidity_percent,
  output logic                               crc_error,
  input  logic                               cfg_write,
  input  logic [htfc_pkg::CfgIndexW-1:0]     cfg_index,
  input  logic [7:0]                         cfg_data
);
  import htfc_pkg::*;

  cfg_t    cfg;
  frame_t  front_frame;
  frame_t  queued_frame;
  result_t back_res;
  result_t head_res;
  logic    front_push;
  logic    frame_full;
  logic    frame_empty;
  logic    frame_pop;
  logic    res_push;
  logic    res_full;

  // Configuration registers; writes to an unused index are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.temp_offset  <= TempOffsetReset;
      cfg.temp_floor   <= TempFloorReset;
      cfg.temp_ceiling <= TempCeilingReset;
    end else if (cfg_write) begin
      case (cfg_index)
        RegTempOffset:  cfg.temp_offset  <= cfg_data[4:0];
        RegTempFloor:   cfg.temp_floor   <= cfg_data;
        RegTempCeiling: cfg.temp_ceiling <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front: byte assembly and CRC check
  htfc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .rx_byte    (rx_byte),
    .full       (full),
    .frame_full (frame_full),
    .frame_push (front_push),
    .frame      (front_frame)
  );

  // Hold checked frames between front and back
  htfc_fifo #(
    .Width ($bits(frame_t)),
    .Depth (FrameDepth)
  ) u_frame_q (
    .clk   (clk),
    .rst   (rst),
    .push  (front_push),
    .wdata (front_frame),
    .full  (frame_full),
    .pop   (frame_pop),
    .rdata (queued_frame),
    .empty (frame_empty)
  );

  // Back: scaling, offset and clamp
  htfc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .frame       (queued_frame),
    .frame_empty (frame_empty),
    .frame_pop   (frame_pop),
    .res_full    (res_full),
    .res_push    (res_push),
    .res         (back_res)
  );

  // Result queue parts the converter from a stalled receiver
  htfc_fifo #(
    .Width ($bits(result_t)),
    .Depth (ResultDepth)
  ) u_result_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (back_res),
    .full  (res_full),
    .pop   (pop),
    .rdata (head_res),
    .empty (empty)
  );

  assign raw_temp         = head_res.raw_temp;
  assign raw_humidity     = head_res.raw_humidity;
  assign temp_degrees     = head_res.temp_degrees;
  assign humidity_percent = head_res.humidity_percent;
  assign crc_error        = head_res.crc_error;

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for humidity_temp_frame_check_convert.
// Needs htfc_pkg for register indexes, byte positions and the result layout.
// Predicts every converted reading from the accepted bytes.
module tb;

  localparam int HalfPeriod     = 10;
  localparam int ResetCycles    = 6;
  localparam int DrainCycles    = 8;
  localparam int LongHoldCycles = 100;   // long enough to back up both internal queues
  localparam int PhaseBytes     = 66;
  localparam int RunLimit       = 4_000_000;

  // Tracks the six-byte answer as the block sees it and keeps the readings
  // still owed by the block, oldest first.
  class reading_scoreboard;
    htfc_pkg::result_t readings_due[$];
    htfc_pkg::pos_t    position;
    logic [7:0]        crc;
    logic [15:0]       temp_word;
    logic [15:0]       hum_word;
    logic              temp_bad;
    logic signed [4:0] offset;
    logic signed [7:0] floor_deg;
    logic signed [7:0] ceil_deg;
    int mismatches;
    int bytes_taken;
    int readings_seen;
    int crc_failures;
    int floor_hits;
    int ceil_hits;

    function new();
      position  = htfc_pkg::PosTempHi;
      crc       = htfc_pkg::CrcInit;
      temp_word = '0;
      hum_word  = '0;
      temp_bad  = 1'b0;
      offset    = htfc_pkg::TempOffsetReset;
      floor_deg = htfc_pkg::TempFloorReset;
      ceil_deg  = htfc_pkg::TempCeilingReset;
    endfunction

    // CRC-8 over one byte, MSB first
    function logic [7:0] crc_step(logic [7:0] c, logic [7:0] b);
      logic [7:0] v;
      v = c ^ b;
      for (int k = 0; k < 8; k++) begin
        v = v[7] ? ({v[6:0], 1'b0} ^ htfc_pkg::CrcPoly) : {v[6:0], 1'b0};
      end
      return v;
    endfunction

    function void set_reg(logic [htfc_pkg::CfgIndexW-1:0] idx, logic [7:0] data);
      case (idx)
        htfc_pkg::RegTempOffset:  offset    = data[4:0];
        htfc_pkg::RegTempFloor:   floor_deg = data;
        htfc_pkg::RegTempCeiling: ceil_deg  = data;
        default: ;
      endcase
    endfunction

    // Note one accepted byte; the sixth byte of an answer owes a reading
    function void take_byte(logic [7:0] b);
      htfc_pkg::result_t r;
      int t;
      int h;
      bytes_taken++;
      case (position)
        htfc_pkg::PosTempHi: begin
          crc       = crc_step(htfc_pkg::CrcInit, b);
          temp_word = {b, 8'h00};
          position  = htfc_pkg::PosTempLo;
        end
        htfc_pkg::PosTempLo: begin
          crc       = crc_step(crc, b);
          temp_word = {temp_word[15:8], b};
          position  = htfc_pkg::PosTempCrc;
        end
        htfc_pkg::PosTempCrc: begin
          temp_bad = (crc != b);
          crc      = htfc_pkg::CrcInit;
          position = htfc_pkg::PosHumHi;
        end
        htfc_pkg::PosHumHi: begin
          crc      = crc_step(htfc_pkg::CrcInit, b);
          hum_word = {b, 8'h00};
          position = htfc_pkg::PosHumLo;
        end
        htfc_pkg::PosHumLo: begin
          crc      = crc_step(crc, b);
          hum_word = {hum_word[15:8], b};
          position = htfc_pkg::PosHumCrc;
        end
        default: begin
          r.raw_temp     = temp_word;
          r.raw_humidity = hum_word;
          r.crc_error    = temp_bad || (crc != b);
          t = 0;
          h = 0;
          if (!r.crc_error) begin
            t = -45 + (175 * int'(temp_word)) / 65535 + int'(offset);
            // ceiling first, floor last: a floor above the ceiling wins
            if (t > int'(ceil_deg)) begin
              t = int'(ceil_deg);
              ceil_hits++;
            end
            if (t < int'(floor_deg)) begin
              t = int'(floor_deg);
              floor_hits++;
            end
            h = -6 + (125 * int'(hum_word)) / 65535;
          end else begin
            crc_failures++;
          end
          r.temp_degrees     = t[7:0];
          r.humidity_percent = h[7:0];
          readings_due.push_back(r);
          position = htfc_pkg::PosTempHi;
          crc      = htfc_pkg::CrcInit;
          temp_bad = 1'b0;
        end
      endcase
    endfunction

    function void field_ok(string name, int want, int seen);
      if (want != seen) begin
        mismatches++;
        $display("%0t: %s expected %0d got %0d", $time, name, want, seen);
      end
    endfunction

    function void check_reading(logic [15:0] raw_t, logic [15:0] raw_h,
                                logic signed [7:0] deg, logic signed [7:0] pct,
                                logic err);
      htfc_pkg::result_t want;
      if (readings_due.size() == 0) begin
        mismatches++;
        $display("%0t: reading arrived with none expected (raw_temp %h raw_humidity %h)",
                 $time, raw_t, raw_h);
        return;
      end
      want = readings_due.pop_front();
      readings_seen++;
      field_ok("raw_temp", want.raw_temp, raw_t);
      field_ok("raw_humidity", want.raw_humidity, raw_h);
      field_ok("temp_degrees", int'(want.temp_degrees), int'(deg));
      field_ok("humidity_percent", int'(want.humidity_percent), int'(pct));
      field_ok("crc_error", want.crc_error, err);
    endfunction

    function int pending();
      return readings_due.size();
    endfunction
  endclass

  // Clock, reset and every block input start at known values
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic [7:0] rx_byte = '0;
  logic pop = 1'b0;
  logic cfg_write = 1'b0;
  logic [htfc_pkg::CfgIndexW-1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  logic full;
  logic empty;
  logic [15:0] raw_temp;
  logic [15:0] raw_humidity;
  logic signed [7:0] temp_degrees;
  logic signed [7:0] humidity_percent;
  logic crc_error;

  reading_scoreboard sb = new();

  int  stall_requests = 0;   // raised by the sender, served by the receiver
  int  stalls_served  = 0;
  int  hold_left      = 0;
  int  run_left       = 0;
  int  gap_left       = 0;
  int  roll           = 0;
  int  blocked_cycles = 0;
  int  phases_run     = 0;
  bit  eager          = 1'b0;  // sender offers bytes back to back

  always #HalfPeriod clk = ~clk;

  humidity_temp_frame_check_convert i_dut (
    .clk              (clk),
    .rst              (rst),
    .push             (push),
    .rx_byte          (rx_byte),
    .full             (full),
    .pop              (pop),
    .empty            (empty),
    .raw_temp         (raw_temp),
    .raw_humidity     (raw_humidity),
    .temp_degrees     (temp_degrees),
    .humidity_percent (humidity_percent),
    .crc_error        (crc_error),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // Receiver: check each popped reading, then choose whether to pop next cycle.
  // Alternate runs of continuous popping with short gaps and the odd long one;
  // serve a long hold whenever the sender asks for one.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        sb.check_reading(raw_temp, raw_humidity, temp_degrees, humidity_percent, crc_error);
      end
      if (stalls_served != stall_requests) begin
        stalls_served++;
        hold_left = LongHoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        if (run_left > 0) begin
          run_left--;
        end else begin
          roll = $urandom_range(0, 99);
          if (roll < 40) begin
            run_left = $urandom_range(5, 40);
          end else if (roll < 90) begin
            gap_left = $urandom_range(1, 3);
          end else begin
            gap_left = $urandom_range(8, 30);
          end
        end
      end
    end
  end

  // Mostly no gap, often a short one, now and then a long one
  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (eager || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 20);
  endfunction

  // Offer one byte and hold it until the block takes it.
  // Drop push only when a gap is taken, so push never toggles within one step.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      push    <= 1'b0;
      rx_byte <= 8'($urandom);
      repeat (gap) @(posedge clk);
    end
    push    <= 1'b1;
    rx_byte <= b;
    do begin
      @(posedge clk);
      if (full) blocked_cycles++;
    end while (full);
    sb.take_byte(b);
  endtask

  // Send one answer; a non-zero flip corrupts that word's CRC byte
  task automatic send_answer(input logic [15:0] tw, input logic [15:0] hw,
                             input logic [7:0] temp_flip, input logic [7:0] hum_flip);
    logic [7:0] tc;
    logic [7:0] hc;
    tc = sb.crc_step(sb.crc_step(htfc_pkg::CrcInit, tw[15:8]), tw[7:0]);
    hc = sb.crc_step(sb.crc_step(htfc_pkg::CrcInit, hw[15:8]), hw[7:0]);
    send_byte(tw[15:8]);
    send_byte(tw[7:0]);
    send_byte(tc ^ temp_flip);
    send_byte(hw[15:8]);
    send_byte(hw[7:0]);
    send_byte(hc ^ hum_flip);
  endtask

  task automatic send_noise(input int n);
    repeat (n) send_byte(8'($urandom));
  endtask

  // Words near the ends of the range turn up more often than by chance
  function automatic logic [15:0] pick_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return 16'h0000;
    if (r < 8) return 16'hFFFF;
    if (r < 10) return 16'($urandom_range(0, 3)) ^ {16{r[0]}};
    return 16'($urandom);
  endfunction

  // Stop offering bytes and let every owed reading drain out
  task automatic settle();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Write all three registers on consecutive edges; spare offset bits are random
  task automatic load_settings(input int offset, input int floor_deg, input int ceil_deg);
    logic [31:0] ob;
    logic [31:0] fb;
    logic [31:0] cb;
    ob = offset;
    fb = floor_deg;
    cb = ceil_deg;
    cfg_write <= 1'b1;
    cfg_index <= htfc_pkg::RegTempOffset;
    cfg_data  <= {3'($urandom_range(0, 7)), ob[4:0]};
    @(posedge clk);
    sb.set_reg(cfg_index, cfg_data);
    cfg_index <= htfc_pkg::RegTempFloor;
    cfg_data  <= fb[7:0];
    @(posedge clk);
    sb.set_reg(cfg_index, cfg_data);
    cfg_index <= htfc_pkg::RegTempCeiling;
    cfg_data  <= cb[7:0];
    @(posedge clk);
    sb.set_reg(cfg_index, cfg_data);
    cfg_write <= 1'b0;
  endtask

  // Mostly clean answers with random words; some bad CRCs, some pure noise,
  // and misaligned stretches that are put back in step afterwards
  task automatic random_phase(input int nbytes);
    int start;
    int r;
    int n;
    start = sb.bytes_taken;
    while (sb.bytes_taken - start < nbytes) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        send_answer(pick_word(), pick_word(), 8'h00, 8'h00);
      end else if (r < 90) begin
        n = $urandom_range(0, 2);
        send_answer(pick_word(), pick_word(),
                    (n != 1) ? 8'($urandom_range(1, 255)) : 8'h00,
                    (n != 0) ? 8'($urandom_range(1, 255)) : 8'h00);
      end else if (r < 95) begin
        send_noise(6);
      end else begin
        n = $urandom_range(1, 5);
        send_noise(n);
        send_answer(pick_word(), pick_word(), 8'h00, 8'h00);
        send_noise(6 - n);
      end
    end
  endtask

  initial begin
    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed answers under the reset settings: both words at each extreme,
    // so the floor and ceiling clamps both bite, then a bad CRC on each word
    // to show the raw words survive while the readings go to zero
    send_answer(16'h0000, 16'hFFFF, 8'h00, 8'h00);
    send_answer(16'hFFFF, 16'h0000, 8'h00, 8'h00);
    send_answer(16'h6666, 16'h8000, 8'h01, 8'h00);
    send_answer(16'h9999, 16'h4000, 8'h00, 8'h80);

    for (int phase = 0; phase < 6; phase++) begin
      settle();
      eager = (phase == 0) || (phase == 3);
      case (phase)
        0: load_settings(-16, -64, 127);
        1: load_settings(15, -64, 127);
        2: load_settings($urandom_range(0, 31) - 16, 60, 20);    // floor above ceiling
        3: load_settings(0, 127, -64);
        4: load_settings($urandom_range(0, 31) - 16, $urandom_range(0, 191) - 64,
                         $urandom_range(0, 191) - 64);
        default: load_settings(-5, 0, 100);
      endcase
      // Hold the receiver off while bytes keep coming, so the block fills and stalls
      if (phase == 0) stall_requests++;
      random_phase(PhaseBytes);
      phases_run++;
    end

    settle();
    $display("Covered %0d bytes in %0d readings (%0d with CRC errors) over %0d settings",
             sb.bytes_taken, sb.readings_seen, sb.crc_failures, phases_run + 1);
    $display("Clamped to floor %0d times, to ceiling %0d times; input held off %0d cycles",
             sb.floor_hits, sb.ceil_hits, blocked_cycles);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Guard against a hang: far beyond the slowest correct run
  initial begin
    #RunLimit;
    $display("Timed out with %0d readings still owed", sb.pending());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
